/* hw/rtl/cle_pkg.sv */
package cle_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    localparam logic [VALUE_W-1:0] READ_FAIL_VALUE = '1;

    typedef struct packed {
        logic link_we;
        logic value_we;
    } node_we_t;

endpackage

/* hw/rtl/cle_node_mem.sv */
module cle_node_mem #(
    parameter int SLOTS = cle_pkg::CAPACITY_DEF,
    parameter int SW    = $clog2(cle_pkg::CAPACITY_DEF)
) (
    input  logic                           clk,
    input  cle_pkg::node_we_t              we,
    input  logic [SW-1:0]                  link_waddr,
    input  logic [SW-1:0]                  link_wdata,
    input  logic [SW-1:0]                  value_waddr,
    input  logic [cle_pkg::VALUE_W-1:0]    value_wdata,
    input  logic [SW-1:0]                  raddr,
    output logic [SW-1:0]                  link_rdata,
    output logic [cle_pkg::VALUE_W-1:0]    value_rdata
);

    logic [SW-1:0]               link_mem  [SLOTS];
    logic [cle_pkg::VALUE_W-1:0] value_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_rdata <= value_mem[raddr];
    end

endmodule

/* hw/rtl/circular_list_engine_core.sv */
// A failed command goes straight to the result; append and insert pop a free slot,
// walk the links to the insert point and link the new node in (a node into an empty
// list links to itself); read walks to the position, and delete walks to the node
// before it and unlinks it. Commands are taken one at a time, and the link walk does
// one node-link memory read per cycle.
// Reset (rst_n low, asynchronous): list empty, all slots free; the free-slot stack
// uses a low-water mark instead of a clearing pass, so no start-up delay.
module circular_list_engine_core #(
    parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cle_pkg::CMD_W-1:0]           command,
    input  logic signed [cle_pkg::POS_W-1:0]    position,
    input  logic signed [cle_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cle_pkg::VALUE_W-1:0]  read_value,
    output logic [cle_pkg::STATUS_W-1:0]        status,
    output logic [cle_pkg::COUNT_W-1:0]         entry_count
);

    localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > cle_pkg::POS_W) ? CW + 1 : cle_pkg::POS_W + 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_POP    = 7'b0000010,
        ST_WALK   = 7'b0000100,
        ST_AFTER  = 7'b0001000,
        ST_LINK   = 7'b0010000,
        ST_UNLINK = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        KIND_HEAD = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_MID  = 2'd2
    } kind_t;

    state_t                          state_reg, state_next;
    kind_t                           kind_reg, kind_next;
    logic [cle_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [cle_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [cle_pkg::VALUE_W-1:0]     val_reg, val_next;
    logic [CW-1:0]                   len_reg, len_next;
    logic [CW-1:0]                   fc_reg, fc_next;
    logic [CW-1:0]                   low_reg, low_next;
    logic [CW-1:0]                   steps_reg, steps_next;
    logic [SW-1:0]                   head_reg, head_next;
    logic [SW-1:0]                   tail_reg, tail_next;
    logic [SW-1:0]                   cur_reg, cur_next;
    logic [SW-1:0]                   slot_reg, slot_next;
    logic                            chain_reg, chain_next;
    logic [cle_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [cle_pkg::VALUE_W-1:0]     rd_reg, rd_next;
    logic                            out_valid_reg, out_valid_next;
    logic [cle_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [cle_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [cle_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    logic [SW-1:0]                   free_mem [CAPACITY];
    logic [SW-1:0]                   free_rd_q;
    logic                            free_we;
    logic [CW-1:0]                   fc_dec;
    logic [SW-1:0]                   pop_idx;
    logic [SW-1:0]                   pop_slot;

    cle_pkg::node_we_t               node_we;
    logic [SW-1:0]                   link_waddr;
    logic [SW-1:0]                   link_wdata;
    logic [SW-1:0]                   node_raddr;
    logic [SW-1:0]                   link_rdata;
    logic [cle_pkg::VALUE_W-1:0]     value_rdata;
    logic [SW-1:0]                   cur_now;

    logic [CMPW-1:0]                 pos_u;
    logic [CMPW-1:0]                 len_u;
    logic                            pos_neg;
    logic                            pos_zero;
    logic                            pos_over;

    assign fc_dec   = fc_reg - CW'(1);
    assign pop_idx  = fc_dec[SW-1:0];
    assign pop_slot = (fc_dec < low_reg) ? pop_idx : free_rd_q;
    assign cur_now  = chain_reg ? link_rdata : cur_reg;

    assign pos_u    = CMPW'(position[cle_pkg::POS_W-2:0]);
    assign len_u    = CMPW'(len_reg);
    assign pos_neg  = position[cle_pkg::POS_W-1];
    assign pos_zero = (position == '0);
    assign pos_over = !pos_neg && (pos_u >= len_u);

    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[fc_reg[SW-1:0]] <= slot_reg;
        end
        free_rd_q <= free_mem[pop_idx];
    end

    cle_node_mem #(
        .SLOTS (CAPACITY),
        .SW    (SW)
    ) u_node_mem (
        .clk         (clk),
        .we          (node_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .value_waddr (pop_slot),
        .value_wdata (val_reg),
        .raddr       (node_raddr),
        .link_rdata  (link_rdata),
        .value_rdata (value_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        len_next        = len_reg;
        fc_next         = fc_reg;
        low_next        = low_reg;
        steps_next      = steps_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        chain_next      = chain_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        node_we         = '0;
        link_waddr      = cur_reg;
        link_wdata      = slot_reg;
        node_raddr      = cur_reg;
        free_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    pos_next    = position;
                    val_next    = value;
                    rd_next     = '0;
                    status_next = cle_pkg::STAT_OK;
                    chain_next  = 1'b0;
                    case (command)
                        cle_pkg::CMD_APPEND, cle_pkg::CMD_INSERT:
                        begin
                            if (command == cle_pkg::CMD_APPEND)
                            begin
                                kind_next = KIND_TAIL;
                            end
                            else if (pos_neg || pos_zero)
                            begin
                                kind_next = KIND_HEAD;
                            end
                            else if (pos_over)
                            begin
                                kind_next = KIND_TAIL;
                            end
                            else
                            begin
                                kind_next = KIND_MID;
                            end
                            if (len_reg == CW'(CAPACITY))
                            begin
                                status_next = cle_pkg::STAT_FULL;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        default:
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = cle_pkg::STAT_EMPTY;
                                if (command == cle_pkg::CMD_READ)
                                begin
                                    rd_next = cle_pkg::READ_FAIL_VALUE;
                                end
                                state_next = ST_FIN;
                            end
                            else if (pos_neg || pos_over)
                            begin
                                status_next = cle_pkg::STAT_RANGE;
                                if (command == cle_pkg::CMD_READ)
                                begin
                                    rd_next = cle_pkg::READ_FAIL_VALUE;
                                end
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                cur_next   = (command == cle_pkg::CMD_READ) ? head_reg : tail_reg;
                                steps_next = CW'(position[cle_pkg::POS_W-2:0]);
                                state_next = ST_WALK;
                            end
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                slot_next        = pop_slot;
                fc_next          = fc_dec;
                node_we.value_we = 1'b1;
                if (fc_dec < low_reg)
                begin
                    low_next = fc_dec;
                end
                if (len_reg == '0)
                begin
                    node_we.link_we = 1'b1;
                    link_waddr      = pop_slot;
                    link_wdata      = pop_slot;
                    head_next       = pop_slot;
                    tail_next       = pop_slot;
                    len_next        = len_reg + CW'(1);
                    state_next      = ST_FIN;
                end
                else
                begin
                    cur_next   = tail_reg;
                    steps_next = (kind_reg == KIND_MID) ?
                                 CW'(pos_reg[cle_pkg::POS_W-2:0]) : '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                node_raddr = cur_now;
                cur_next   = cur_now;
                if (steps_reg == '0)
                begin
                    state_next = ST_AFTER;
                end
                else
                begin
                    steps_next = steps_reg - CW'(1);
                    chain_next = 1'b1;
                end
            end

            ST_AFTER:
            begin
                case (cmd_reg)
                    cle_pkg::CMD_READ:
                    begin
                        rd_next    = value_rdata;
                        state_next = ST_FIN;
                    end
                    cle_pkg::CMD_DELETE:
                    begin
                        slot_next  = link_rdata;
                        node_raddr = link_rdata;
                        state_next = ST_UNLINK;
                    end
                    default:
                    begin
                        node_we.link_we = 1'b1;
                        link_waddr      = slot_reg;
                        link_wdata      = link_rdata;
                        state_next      = ST_LINK;
                    end
                endcase
            end

            ST_LINK:
            begin
                node_we.link_we = 1'b1;
                link_waddr      = cur_reg;
                link_wdata      = slot_reg;
                if (kind_reg == KIND_HEAD)
                begin
                    head_next = slot_reg;
                end
                if (kind_reg == KIND_TAIL)
                begin
                    tail_next = slot_reg;
                end
                len_next   = len_reg + CW'(1);
                state_next = ST_FIN;
            end

            ST_UNLINK:
            begin
                node_we.link_we = 1'b1;
                link_waddr      = cur_reg;
                link_wdata      = link_rdata;
                if (slot_reg == tail_reg)
                begin
                    tail_next = cur_reg;
                end
                if (slot_reg == head_reg)
                begin
                    head_next = link_rdata;
                end
                free_we    = 1'b1;
                fc_next    = fc_reg + CW'(1);
                len_next   = len_reg - CW'(1);
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_reg;
                    out_status_next = status_reg;
                    out_count_next  = cle_pkg::COUNT_W'(len_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            fc_reg        <= CW'(CAPACITY);
            low_reg       <= CW'(CAPACITY);
            head_reg      <= '0;
            tail_reg      <= '0;
            steps_reg     <= '0;
            chain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fc_reg        <= fc_next;
            low_reg       <= low_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            steps_reg     <= steps_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign read_value  = out_value_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FIN)
            |-> ((32'(len_reg) + 32'(fc_reg)) == 32'(CAPACITY)))
        else $error("entry count and free count do not cover all slots");

    a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= fc_reg)
        else $error("free stack low-water mark above free count");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && status_reg == cle_pkg::STAT_FULL)
            |-> (len_reg == CW'(CAPACITY)))
        else $error("full status reported on a list with free slots");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

endmodule

/* bench/circular_list_engine_core_test.sv */
`timescale 1ns / 1ps

module circular_list_engine_core_test;

    localparam int CAP         = cle_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 308;

    typedef struct {
        logic [cle_pkg::CMD_W-1:0]          cmd;
        logic signed [cle_pkg::POS_W-1:0]   pos;
        logic signed [cle_pkg::VALUE_W-1:0] val;
        int                                 phase;
    } list_cmd_t;

    typedef struct packed {
        logic [cle_pkg::VALUE_W-1:0]  read_value;
        logic [cle_pkg::STATUS_W-1:0] status;
        logic [cle_pkg::COUNT_W-1:0]  entry_count;
    } list_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [cle_pkg::CMD_W-1:0]            command = cle_pkg::CMD_APPEND;
    logic signed [cle_pkg::POS_W-1:0]     position = '0;
    logic signed [cle_pkg::VALUE_W-1:0]   value = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [cle_pkg::VALUE_W-1:0]   read_value;
    logic [cle_pkg::STATUS_W-1:0]         status;
    logic [cle_pkg::COUNT_W-1:0]          entry_count;

    list_cmd_t                            staged_cmds[$];
    list_result_t                         awaited_results[$];
    logic signed [cle_pkg::VALUE_W-1:0]   shadow_list[$];
    list_cmd_t                            next_cmd;
    list_result_t                         want;
    int                                   plan_len = 0;
    int                                   cur_phase = 0;
    int                                   hold_left = 0;
    bit                                   hold_done = 1'b0;
    int                                   stall_cycles = 0;
    int                                   failures = 0;
    int                                   peak_len = 0;
    int                                   cmd_tally[4] = '{0, 0, 0, 0};
    int                                   status_tally[4] = '{0, 0, 0, 0};

    circular_list_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int sender_idle_pct(int phase);
        case (phase)
            0:       return 20;
            1:       return 64;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(int phase);
        case (phase)
            0:       return 64;
            1:       return 20;
            default: return 0;
        endcase
    endfunction

    // Positional list behavior: head, tail and middle insert, delete and read by index.
    function automatic list_result_t run_command(logic [cle_pkg::CMD_W-1:0] cmd,
                                                 logic signed [cle_pkg::POS_W-1:0] pos,
                                                 logic signed [cle_pkg::VALUE_W-1:0] val);
        list_result_t r;
        int           p;
        r.read_value = '0;
        r.status     = cle_pkg::STAT_OK;
        p            = pos;
        if (cmd == cle_pkg::CMD_APPEND || cmd == cle_pkg::CMD_INSERT)
        begin
            if (shadow_list.size() >= CAP)
                r.status = cle_pkg::STAT_FULL;
            else if (cmd == cle_pkg::CMD_APPEND || p >= shadow_list.size())
                shadow_list.push_back(val);
            else if (p <= 0)
                shadow_list.push_front(val);
            else
                shadow_list.insert(p, val);
        end
        else
        begin
            if (shadow_list.size() == 0)
                r.status = cle_pkg::STAT_EMPTY;
            else if (p < 0 || p >= shadow_list.size())
                r.status = cle_pkg::STAT_RANGE;
            if (r.status != cle_pkg::STAT_OK)
            begin
                if (cmd == cle_pkg::CMD_READ)
                    r.read_value = cle_pkg::READ_FAIL_VALUE;
            end
            else if (cmd == cle_pkg::CMD_READ)
                r.read_value = shadow_list[p];
            else
                shadow_list.delete(p);
        end
        r.entry_count = cle_pkg::COUNT_W'(shadow_list.size());
        return r;
    endfunction

    function automatic void stage(logic [cle_pkg::CMD_W-1:0] cmd,
                                  logic signed [cle_pkg::POS_W-1:0] pos,
                                  logic signed [cle_pkg::VALUE_W-1:0] val, int phase);
        list_cmd_t c;
        int        p;
        c.cmd   = cmd;
        c.pos   = pos;
        c.val   = val;
        c.phase = phase;
        p       = pos;
        staged_cmds.push_back(c);
        if (cmd == cle_pkg::CMD_APPEND || cmd == cle_pkg::CMD_INSERT)
        begin
            if (plan_len < CAP)
                plan_len++;
        end
        else if (cmd == cle_pkg::CMD_DELETE && plan_len > 0 && p >= 0 && p < plan_len)
            plan_len--;
    endfunction

    function automatic logic signed [cle_pkg::POS_W-1:0] pick_position(bit noise);
        int roll;
        roll = $urandom_range(99);
        if (noise || roll < 6)
            return cle_pkg::POS_W'($urandom);
        if (roll < 12)
            return cle_pkg::POS_W'(-int'($urandom_range(40, 1)));
        if (roll < 20 || plan_len == 0)
            return cle_pkg::POS_W'(plan_len + int'($urandom_range(3)));
        return cle_pkg::POS_W'($urandom_range(plan_len - 1));
    endfunction

    // Styles: 0-3 grow, 4-5 shrink, 6-8 mixed, 9 noise.
    function automatic logic [cle_pkg::CMD_W-1:0] pick_command(int style);
        int roll;
        roll = $urandom_range(99);
        if (style <= 3)
        begin
            if (roll < 45)
                return cle_pkg::CMD_INSERT;
            if (roll < 80)
                return cle_pkg::CMD_APPEND;
            return cle_pkg::CMD_READ;
        end
        if (style <= 5)
        begin
            if (roll < 65)
                return cle_pkg::CMD_DELETE;
            if (roll < 90)
                return cle_pkg::CMD_READ;
            return cle_pkg::CMD_INSERT;
        end
        return cle_pkg::CMD_W'(roll % 4);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (staged_cmds.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(staged_cmds[0].phase))
            begin
                next_cmd = staged_cmds.pop_front();
                in_valid  <= 1'b1;
                command   <= next_cmd.cmd;
                position  <= next_cmd.pos;
                value     <= next_cmd.val;
                cur_phase <= next_cmd.phase;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (cur_phase == 2 && !hold_done)
        begin
            // hold off the result so the block backs up its input
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct(cur_phase));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                status_tally[status]++;
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), read_value);
                        failures++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failures++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, entry_count);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                cmd_tally[command]++;
                awaited_results.push_back(run_command(command, position, value));
                if (shadow_list.size() > peak_len)
                    peak_len = shadow_list.size();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("circular_list_engine_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int target;
        int style;
        int run;

        // empty list
        stage(cle_pkg::CMD_READ, 16'sd0, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd0, 32'sd0, 0);
        stage(cle_pkg::CMD_READ, -16'sd1, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sh7FFF, 32'sd0, 0);
        // insert into empty list, then head, tail and middle
        stage(cle_pkg::CMD_INSERT, 16'sd5, 32'sh7FFF_FFFF, 0);
        stage(cle_pkg::CMD_APPEND, 16'sd0, 32'sh8000_0000, 0);
        stage(cle_pkg::CMD_INSERT, 16'sh8000, -32'sd1, 0);
        stage(cle_pkg::CMD_INSERT, 16'sh7FFF, 32'sd0, 0);
        stage(cle_pkg::CMD_INSERT, 16'sd2, 32'sh1234_5678, 0);
        for (int i = 0; i < 5; i++)
            stage(cle_pkg::CMD_READ, cle_pkg::POS_W'(i), 32'sd0, 0);
        // out of range
        stage(cle_pkg::CMD_READ, 16'sd5, 32'sd0, 0);
        stage(cle_pkg::CMD_READ, 16'sh8000, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd5, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, -16'sd1, 32'sd0, 0);
        // middle, tail, head, then down to empty
        stage(cle_pkg::CMD_DELETE, 16'sd2, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd3, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd0, 32'sd0, 0);
        stage(cle_pkg::CMD_READ, 16'sd1, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd1, 32'sd0, 0);
        stage(cle_pkg::CMD_DELETE, 16'sd0, 32'sd0, 0);
        stage(cle_pkg::CMD_READ, 16'sd0, 32'sd0, 0);

        for (ph = 0; ph < 3; ph++)
        begin
            target = staged_cmds.size() + PHASE_ITEMS;
            if (ph == 1)
            begin
                // fill to capacity, then push past it
                while (plan_len < CAP)
                    stage($urandom_range(1) ? cle_pkg::CMD_INSERT : cle_pkg::CMD_APPEND,
                          pick_position(1'b0), $urandom, ph);
                stage(cle_pkg::CMD_APPEND, 16'sd0, $urandom, ph);
                stage(cle_pkg::CMD_INSERT, 16'sd0, $urandom, ph);
                stage(cle_pkg::CMD_INSERT, 16'sd100, $urandom, ph);
                stage(cle_pkg::CMD_READ, 16'(CAP - 1), 32'sd0, ph);
            end
            while (staged_cmds.size() < target)
            begin
                style = $urandom_range(9);
                run   = $urandom_range(40, 10);
                for (int k = 0; k < run && staged_cmds.size() < target; k++)
                    stage(style == 9 ? cle_pkg::CMD_W'($urandom) : pick_command(style),
                          pick_position(style == 9), $urandom, ph);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (staged_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Ran %0d commands: append %0d, insert %0d, delete %0d, read %0d",
                 cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
                 cmd_tally[cle_pkg::CMD_APPEND], cmd_tally[cle_pkg::CMD_INSERT],
                 cmd_tally[cle_pkg::CMD_DELETE], cmd_tally[cle_pkg::CMD_READ]);
        $display("Peak length %0d; outcomes: ok %0d, empty %0d, out of range %0d, full %0d",
                 peak_len, status_tally[cle_pkg::STAT_OK], status_tally[cle_pkg::STAT_EMPTY],
                 status_tally[cle_pkg::STAT_RANGE], status_tally[cle_pkg::STAT_FULL]);
        if (failures == 0)
            $display("circular_list_engine_core_test OK");
        else
            $display("circular_list_engine_core_test NOT OK");
        $finish;
    end

endmodule
